// ===== sv/cle_pkg.sv =====
// shared types and constants for the console line editor
package cle_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int LINE_CAP     = BUFFER_BYTES - 2;
    localparam int LEN_W        = $clog2(LINE_CAP + 1);
    localparam int IDX_W        = $clog2(LINE_CAP);

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd127;

    typedef enum logic [1:0] {
        K_PRINT,
        K_BS,
        K_CR,
        K_IGNORE
    } t_kind;

    typedef struct packed {
        logic       prompt;
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_CHAR,
        BODY_BS,
        BODY_CR
    } t_body;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_CR,
        S_PRE_LF,
        S_PRE_GT,
        S_CHAR,
        S_BS1,
        S_SP,
        S_BS2,
        S_CR,
        S_LF,
        S_DUMP,
        S_POST_CR,
        S_POST_LF,
        S_POST_GT
    } t_state;

endpackage

// ===== sv/cle_cmd_queue.sv =====
// small command queue between the classifier and the transmit sequencer
module cle_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cle_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output cle_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import cle_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/cle_front.sv =====
// receive side: takes rx bytes, classifies them and queues commands
module cle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,
    output logic          o_push,
    output cle_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import cle_pkg::*;

    logic  r_prompt_pending;
    t_kind kind;
    logic  accept;

    always_comb begin
        if (i_s_tdata >= CH_PRINT_LO && i_s_tdata <= CH_PRINT_HI) begin
            kind = K_PRINT;
        end else if (i_s_tdata == CH_CR) begin
            kind = K_CR;
        end else if (i_s_tdata == CH_BS) begin
            kind = K_BS;
        end else begin
            kind = K_IGNORE;
        end
    end

    assign o_s_tready  = !i_full;
    assign accept      = i_s_tvalid && !i_full;
    // ignored bytes only need a queue slot when they carry the first prompt
    assign o_push      = accept && (kind != K_IGNORE || r_prompt_pending);
    assign o_cmd.prompt = r_prompt_pending;
    assign o_cmd.kind   = kind;
    assign o_cmd.ch     = i_s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prompt_pending <= 1'b1;
        end else if (accept) begin
            r_prompt_pending <= 1'b0;
        end
    end

endmodule

// ===== sv/cle_back.sv =====
// transmit side: line store, edit state and byte sequencer
module cle_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cle_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [7:0]    o_m_tdata,
    output logic          o_m_tlast
);
    import cle_pkg::*;

    logic [7:0]       r_mem [LINE_CAP];
    logic [7:0]       r_rd_data;

    t_state           r_state, n_state;
    t_body            r_body, n_body;
    logic [7:0]       r_ch, n_ch;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_dump_len, n_dump_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] idx_inc;

    logic             r_m_valid;
    logic [7:0]       r_m_data;
    logic             r_m_last;

    logic             out_free;
    logic             load;
    logic [7:0]       ld_byte;
    logic             ld_last;
    logic             wr_en;
    t_body            eff_body;

    function automatic t_state body_start(input t_body b);
        case (b)
            BODY_CHAR: body_start = S_CHAR;
            BODY_BS:   body_start = S_BS1;
            BODY_CR:   body_start = S_CR;
            default:   body_start = S_IDLE;
        endcase
    endfunction

    assign out_free = !r_m_valid || i_m_tready;
    assign idx_inc  = r_idx + 1'b1;

    // what the popped command really does given the current line
    always_comb begin
        case (i_cmd.kind)
            K_PRINT: eff_body = (r_len < LEN_W'(LINE_CAP)) ? BODY_CHAR : BODY_NONE;
            K_BS:    eff_body = (r_len != '0) ? BODY_BS : BODY_NONE;
            K_CR:    eff_body = BODY_CR;
            default: eff_body = BODY_NONE;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_body     = r_body;
        n_ch       = r_ch;
        n_len      = r_len;
        n_dump_len = r_dump_len;
        n_idx      = r_idx;
        o_pop      = 1'b0;
        load       = 1'b0;
        ld_byte    = CH_CR;
        ld_last    = 1'b0;
        wr_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_body = eff_body;
                    n_ch   = i_cmd.ch;
                    n_state = i_cmd.prompt ? S_PRE_CR : body_start(eff_body);
                    case (eff_body)
                        BODY_CHAR: begin
                            wr_en = 1'b1;
                            n_len = r_len + 1'b1;
                        end
                        BODY_BS: n_len = r_len - 1'b1;
                        BODY_CR: begin
                            n_dump_len = r_len;
                            n_len      = '0;
                        end
                        default: n_len = r_len;
                    endcase
                end
            end
            S_PRE_CR, S_CR, S_POST_CR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_CR;
                    case (r_state)
                        S_PRE_CR: n_state = S_PRE_LF;
                        S_CR:     n_state = S_LF;
                        default:  n_state = S_POST_LF;
                    endcase
                end
            end
            S_PRE_LF, S_POST_LF: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_LF;
                    n_state = (r_state == S_PRE_LF) ? S_PRE_GT : S_POST_GT;
                end
            end
            S_LF: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_LF;
                    n_idx   = '0;
                    n_state = (r_dump_len == '0) ? S_POST_CR : S_DUMP;
                end
            end
            S_PRE_GT: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_GT;
                    ld_last = (r_body == BODY_NONE);
                    n_state = body_start(r_body);
                end
            end
            S_POST_GT: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_GT;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHAR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = r_ch;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BS1: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_BS;
                    n_state = S_SP;
                end
            end
            S_SP: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_SP;
                    n_state = S_BS2;
                end
            end
            S_BS2: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = CH_BS;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = r_rd_data;
                    n_idx   = idx_inc;
                    if (idx_inc == r_dump_len) begin
                        n_state = S_POST_CR;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // line store: one write port at the line end, registered read that follows n_idx
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_len[IDX_W-1:0]] <= i_cmd.ch;
        end
        r_rd_data <= r_mem[n_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_idx     <= '0;
            r_body    <= BODY_NONE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_body  <= n_body;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch       <= n_ch;
        r_dump_len <= n_dump_len;
        if (load) begin
            r_m_data <= ld_byte;
            r_m_last <= ld_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_CAP))
        else $error("line length past capacity");

    a_dump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_idx < r_dump_len))
        else $error("dump index past stored line");

    a_prompt_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.prompt) |=> (r_state == S_PRE_CR))
        else $error("prompt not sent first");
`endif

endmodule

// ===== sv/console_line_editor_echo.sv =====
// top level of the serial console line editor with echo
// Each received byte is one slave-side transfer; the block answers with zero or more
// transmit bytes on the master side, tlast marking the final byte caused by that rx
// byte. The first rx byte after reset is preceded by the prompt CR LF '>'. Printable
// bytes (32..127) go into a 30-byte line store and are echoed, or are dropped silently
// once the line is full; backspace on a non-empty line sends BS SP BS; CR sends CR LF,
// the stored line and a new prompt, then empties the line; all other bytes are ignored.
// A classifier feeds a four-entry command queue, so rx transfers keep being taken
// while the transmit sequencer works, until the queue fills. The sequencer takes a
// command from the queue in its idle state and then loads one transmit byte per
// cycle while tx back pressure does not hold it.
module console_line_editor_echo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] tx_byte
    output logic       o_m_tlast    // last_of_run
);
    import cle_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // front: classify and queue
    cle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    cle_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    // back: edit the line and sequence the transmit bytes
    cle_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== sim/console_line_editor_echo_checker.sv =====
// checker for the console line editor: predicts the transmit bytes and compares them
module console_line_editor_echo_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] tx_byte
    input  logic       i_m_tlast,   // last_of_run
    output int         o_fail_count,
    output int         o_open_count
);
    import cle_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_tx_beat;

    t_tx_beat         tx_expected[$];
    t_tx_beat         echo_run[$];
    t_tx_beat         got_beat;
    logic [7:0]       line_mem [LINE_CAP];
    logic [LEN_W-1:0] line_len;
    logic             prompt_owed;
    int               fails;

    function automatic t_kind classify_rx(input logic [7:0] ch);
        if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) return K_PRINT;
        if (ch == CH_CR) return K_CR;
        if (ch == CH_BS) return K_BS;
        return K_IGNORE;
    endfunction

    task automatic put_char(input logic [7:0] ch);
        echo_run.push_back('{ch: ch, last: 1'b0});
    endtask

    task automatic put_prompt();
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(CH_GT);
    endtask

    // bytes the editor answers one rx byte with, in order
    task automatic predict_echo(input logic [7:0] rx);
        int i;
        echo_run.delete();
        if (prompt_owed) begin
            put_prompt();
            prompt_owed = 1'b0;
        end
        case (classify_rx(rx))
            K_PRINT: begin
                // full line drops the byte silently
                if (line_len < LINE_CAP) begin
                    line_mem[line_len] = rx;
                    line_len = line_len + 1'b1;
                    put_char(rx);
                end
            end
            K_CR: begin
                put_char(CH_CR);
                put_char(CH_LF);
                for (i = 0; i < int'(line_len); i++) put_char(line_mem[i]);
                put_prompt();
                line_len = '0;
            end
            K_BS: begin
                if (line_len != 0) begin
                    line_len = line_len - 1'b1;
                    put_char(CH_BS);
                    put_char(CH_SP);
                    put_char(CH_BS);
                end
            end
            default: ;
        endcase
        if (echo_run.size() != 0) echo_run[echo_run.size() - 1].last = 1'b1;
        foreach (echo_run[i]) tx_expected.push_back(echo_run[i]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_expected.delete();
            line_len    = '0;
            prompt_owed = 1'b1;
        end else begin
            // tx first: a transfer can never answer an rx taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (tx_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected tx byte %02h", i_m_tdata));
                end else begin
                    got_beat = tx_expected.pop_front();
                    if (i_m_tdata !== got_beat.ch)
                        report_mismatch($sformatf("tx byte %02h, expected %02h",
                                                  i_m_tdata, got_beat.ch));
                    if (i_m_tlast !== got_beat.last)
                        report_mismatch($sformatf("tlast %b on byte %02h, expected %b",
                                                  i_m_tlast, i_m_tdata, got_beat.last));
                end
            end
            if (i_s_tvalid && i_s_tready) predict_echo(i_s_tdata);
        end
        o_open_count <= tx_expected.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb_console_line_editor_echo.sv =====
// testbench top for the console line editor: drives rx bytes, paces tx and gives the verdict
module tb_console_line_editor_echo;
    import cle_pkg::*;

    localparam int HOLD_CYCLES = 200;     // long tx hold-off so the command queue fills
    localparam int CYCLE_LIMIT = 800000;  // far above the slowest legal run
    localparam int OPENING_LEN = 20;

    // opening bytes: first byte is ignored so the prompt forms the whole run,
    // then both printable extremes, backspace down to and past an empty line,
    // ignored control and high bytes, a CR with a line and a CR on an empty line
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        8'h00, CH_PRINT_LO, 8'h41, CH_PRINT_HI, CH_BS, CH_BS, CH_BS, CH_BS,
        8'h80, 8'hFF, 8'h1F, CH_LF, 8'h09, 8'h78, 8'h7E, 8'h3F,
        CH_CR, CH_CR, CH_BS, 8'h5A
    };

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] tx_byte
    logic       m_tlast;            // last_of_run

    int fail_count;
    int open_count;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int rx_edits   = 0;   // rx bytes that are printable, BS or CR
    int cycle_count = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    console_line_editor_echo dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    console_line_editor_echo_checker echo_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    // tx side: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one rx transfer; tvalid stays high between back-to-back bytes and only
    // drops for a gap, so it never gets two assignments in one step
    task automatic send_rx(input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if ((b >= CH_PRINT_LO && b <= CH_PRINT_HI) || b == CH_BS || b == CH_CR)
            rx_edits++;
    endtask

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    endfunction

    // mostly whole lines with random text and stray backspaces, closed by CR;
    // the rest is backspace runs, single printables and raw noise
    task automatic send_random_burst();
        int pick;
        int len;
        int k;
        pick = $urandom_range(99);
        if (pick < 62) begin
            if ($urandom_range(9) == 0) len = $urandom_range(LINE_CAP + 6, LINE_CAP - 4);
            else len = $urandom_range(8);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(99) < 10) send_rx(CH_BS);
                else send_rx(any_printable());
            end
            send_rx(CH_CR);
        end else if (pick < 75) begin
            repeat ($urandom_range(4, 1)) send_rx(CH_BS);
        end else if (pick < 85) begin
            send_rx(any_printable());
        end else begin
            send_rx(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int edits);
        int goal;
        idle_pct  = idle;
        stall_pct = stall;
        goal = rx_edits + edits;
        while (rx_edits < goal) send_random_burst();
    endtask

    initial begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[k]) send_rx(OPENING[k]);

        // hold tx off while rx keeps offering a line that overruns the store:
        // the queue fills and rx stalls, the extra bytes are dropped silently
        hold_req++;
        for (k = 0; k < LINE_CAP + 4; k++) send_rx(any_printable());
        send_rx(CH_BS);
        send_rx(any_printable());
        send_rx(any_printable());
        send_rx(CH_CR);

        run_phase(0, 0, 105);
        run_phase(74, 0, 105);
        run_phase(0, 74, 105);
        run_phase(25, 25, 105);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        // ignored bytes may still sit in the command queue
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cle_pkg.sv
sv/cle_cmd_queue.sv
sv/cle_front.sv
sv/cle_back.sv
sv/console_line_editor_echo.sv
sim/console_line_editor_echo_checker.sv
sim/tb_console_line_editor_echo.sv
